[rtl/core/igc_pkg.sv]
// ----------------------------------------------------------------------------
// igc_pkg
// Shared widths, codes, stage bundles and the saturation helper for the
// ideal-gas conserved-to-primitive pipeline.
// ----------------------------------------------------------------------------
package igc_pkg;

	localparam int WORD_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int GAMMA_W    = 18;
	localparam int GAMMA_FRAC = 16;
	localparam int NUM_AXES   = 3;
	localparam int DIV_STEPS  = WORD_W;
	localparam int DIV_COUNT  = NUM_AXES + 1;
	localparam int KE_IDX     = NUM_AXES;

	localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd109227;
	localparam logic [GAMMA_W:0]   GAMMA_ONE   = 19'(1 << GAMMA_FRAC);

	localparam logic [WORD_W-1:0] MAX_WORD = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] MIN_WORD = 32'h8000_0000;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_DENSITY = 2'd1,
		ST_SATURATED   = 2'd2
	} status_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              hit;
	} sat_t;

	// front end output: divider seeds plus what travels alongside
	typedef struct packed {
		logic                             bad_rho;
		logic [WORD_W-1:0]                rho;
		logic [WORD_W-1:0]                et;
		logic [NUM_AXES-1:0]              neg;
		logic [NUM_AXES-1:0]              vel_ovf;
		logic [NUM_AXES-1:0][WORD_W-1:0]  vel_hi;
		logic [NUM_AXES-1:0][WORD_W-1:0]  vel_lo;
		logic [2*WORD_W-1:0]              msq;
	} front_t;

	// carried in step with the dividers
	typedef struct packed {
		logic                bad_rho;
		logic [WORD_W-1:0]   rho;
		logic [WORD_W-1:0]   et;
		logic [NUM_AXES-1:0] neg;
		logic [NUM_AXES-1:0] vel_ovf;
		logic                ke_ovf;
	} side_t;

	typedef struct packed {
		logic [WORD_W-1:0] rho;
		logic [WORD_W-1:0] vx;
		logic [WORD_W-1:0] vy;
		logic [WORD_W-1:0] vz;
		logic [WORD_W-1:0] eint;
		logic [WORD_W-1:0] press;
		status_t           status;
	} prim_t;

	// clamp a 35-bit two's complement value into a word
	function automatic sat_t sat_word(input logic [34:0] v);
		sat_t r;
		if (v[34:31] == {4{v[34]}}) begin
			r.value = v[31:0];
			r.hit   = 1'b0;
		end else begin
			r.value = v[34] ? MIN_WORD : MAX_WORD;
			r.hit   = 1'b1;
		end
		return r;
	endfunction

endpackage

[rtl/core/igc_ifs.sv]
// ----------------------------------------------------------------------------
// igc channel interfaces
// Valid/ready channels for conserved input cells, primitive results and the
// adiabatic index register write.
// ----------------------------------------------------------------------------
interface igc_cons_if;
	logic                      valid;
	logic                      ready;
	logic signed [31:0]        density;
	logic signed [31:0]        momentum_x;
	logic signed [31:0]        momentum_y;
	logic signed [31:0]        momentum_z;
	logic signed [31:0]        total_energy;

	modport source (
		output valid, density, momentum_x, momentum_y, momentum_z, total_energy,
		input  ready
	);
	modport sink (
		input  valid, density, momentum_x, momentum_y, momentum_z, total_energy,
		output ready
	);
endinterface

interface igc_prim_if;
	logic                      valid;
	logic                      ready;
	logic signed [31:0]        rest_density;
	logic signed [31:0]        velocity_x;
	logic signed [31:0]        velocity_y;
	logic signed [31:0]        velocity_z;
	logic signed [31:0]        internal_energy;
	logic signed [31:0]        pressure;
	igc_pkg::status_t          status;

	modport source (
		output valid, rest_density, velocity_x, velocity_y, velocity_z,
		       internal_energy, pressure, status,
		input  ready
	);
	modport sink (
		input  valid, rest_density, velocity_x, velocity_y, velocity_z,
		       internal_energy, pressure, status,
		output ready
	);
endinterface

interface igc_cfg_if;
	logic        valid;
	logic        ready;
	logic [17:0] adiabatic_index;

	modport source (output valid, adiabatic_index, input ready);
	modport sink (input valid, adiabatic_index, output ready);
endinterface

[rtl/core/ideal_gas_cons_to_prim.sv]
// ----------------------------------------------------------------------------
// ideal_gas_cons_to_prim
// Conserved-to-primitive conversion for an ideal gas, one grid cell per clock unless stalled.
// ----------------------------------------------------------------------------
// Channels: cons carries one cell (density, momenta, total energy, Q16.16);
// prim returns rest density, velocities, internal energy, pressure and a
// status code; cfg writes the adiabatic index (unsigned Q2.16). The user must
// write it only while no cell is in flight; the block does not enforce this.
// cfg is always ready. From acceptance to prim.valid a cell passes 3 front
// stages (capture, squares, sum), 32 stages of the one-bit-per-stage dividers,
// 2 back stages (saturation, gamma product) and the output buffer.
// Throughput is one cell per cycle while the output buffer is not full; the
// dividers run side by side, one per velocity component and one for the
// kinetic energy. When the receiver stalls, the two-entry output buffer fills
// and the whole pipeline holds; cons.ready drops as soon as the buffer is full
// and nothing is dropped or repeated. Reset clears all valid flags and sets
// the adiabatic index to about 5/3.
// ----------------------------------------------------------------------------
module ideal_gas_cons_to_prim (
	input  logic      clk,
	input  logic      arst_n,
	igc_cfg_if.sink   cfg,
	igc_cons_if.sink  cons,
	igc_prim_if.source prim
);

	logic                                 en;
	logic                                 skid_full;
	logic [igc_pkg::GAMMA_W-1:0]          gamma_q;

	logic                                 front_valid;
	igc_pkg::front_t                      seed;
	logic [31:0]                          ke_dvs;
	igc_pkg::side_t                       side_in;
	igc_pkg::side_t                       side_s [igc_pkg::DIV_STEPS];
	logic [igc_pkg::DIV_STEPS-1:0]        vld_s;
	logic [igc_pkg::DIV_COUNT-1:0][31:0]  quot;

	logic                                 back_valid;
	igc_pkg::prim_t                       back_res;
	igc_pkg::prim_t                       out_res;

	assign en         = !skid_full;
	assign cons.ready = en;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= igc_pkg::GAMMA_RESET;
		end else if (cfg.valid && cfg.ready) begin
			gamma_q <= cfg.adiabatic_index;
		end
	end

	igc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (cons.valid),
		.density      (cons.density),
		.momentum_x   (cons.momentum_x),
		.momentum_y   (cons.momentum_y),
		.momentum_z   (cons.momentum_z),
		.total_energy (cons.total_energy),
		.out_valid    (front_valid),
		.seed         (seed)
	);

	// kinetic energy divides by twice the density
	assign ke_dvs = {seed.rho[30:0], 1'b0};

	assign side_in = '{
		bad_rho: seed.bad_rho,
		rho:     seed.rho,
		et:      seed.et,
		neg:     seed.neg,
		vel_ovf: seed.vel_ovf,
		ke_ovf:  seed.msq[63:32] >= ke_dvs
	};

	for (genvar i = 0; i < igc_pkg::NUM_AXES; i++) begin : g_vel
		igc_div u_div (
			.clk     (clk),
			.en      (en),
			.rem_in  (seed.vel_hi[i]),
			.bits_in (seed.vel_lo[i]),
			.divisor (seed.rho),
			.quot    (quot[i])
		);
	end

	igc_div u_div_ke (
		.clk     (clk),
		.en      (en),
		.rem_in  (seed.msq[63:32]),
		.bits_in (seed.msq[31:0]),
		.divisor (ke_dvs),
		.quot    (quot[igc_pkg::KE_IDX])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[igc_pkg::DIV_STEPS-2:0], front_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 1; k < igc_pkg::DIV_STEPS; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	igc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s[igc_pkg::DIV_STEPS-1]),
		.side      (side_s[igc_pkg::DIV_STEPS-1]),
		.quot      (quot),
		.gamma     (gamma_q),
		.out_valid (back_valid),
		.res       (back_res)
	);

	igc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && back_valid),
		.data      (back_res),
		.full      (skid_full),
		.out_valid (prim.valid),
		.out_ready (prim.ready),
		.out_data  (out_res)
	);

	assign prim.rest_density    = out_res.rho;
	assign prim.velocity_x      = out_res.vx;
	assign prim.velocity_y      = out_res.vy;
	assign prim.velocity_z      = out_res.vz;
	assign prim.internal_energy = out_res.eint;
	assign prim.pressure        = out_res.press;
	assign prim.status          = out_res.status;

endmodule

[rtl/core/igc_front.sv]
// ----------------------------------------------------------------------------
// igc_front
// Three stages: input capture with magnitudes, momentum squares and velocity
// divider seeds, then the sum of squares.
// ----------------------------------------------------------------------------
module igc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [31:0]   density,
	input  logic signed [31:0]   momentum_x,
	input  logic signed [31:0]   momentum_y,
	input  logic signed [31:0]   momentum_z,
	input  logic signed [31:0]   total_energy,
	output logic                 out_valid,
	output igc_pkg::front_t      seed
);

	logic [igc_pkg::NUM_AXES-1:0][31:0] mom_in;
	logic [igc_pkg::NUM_AXES-1:0][31:0] mag_in;
	logic [igc_pkg::NUM_AXES-1:0]       neg_in;
	logic [igc_pkg::NUM_AXES-1:0][63:0] num;

	logic                               valid_s1, valid_s2, valid_s3;

	logic [31:0]                        rho_s1, et_s1;
	logic [igc_pkg::NUM_AXES-1:0][31:0] mag_s1;
	logic [igc_pkg::NUM_AXES-1:0]       neg_s1;
	logic                               bad_s1;

	logic [31:0]                        rho_s2, et_s2;
	logic [igc_pkg::NUM_AXES-1:0][63:0] sq_s2;
	logic [igc_pkg::NUM_AXES-1:0][31:0] hi_s2, lo_s2;
	logic [igc_pkg::NUM_AXES-1:0]       neg_s2, ovf_s2;
	logic                               bad_s2;

	logic [31:0]                        rho_s3, et_s3;
	logic [63:0]                        msq_s3;
	logic [igc_pkg::NUM_AXES-1:0][31:0] hi_s3, lo_s3;
	logic [igc_pkg::NUM_AXES-1:0]       neg_s3, ovf_s3;
	logic                               bad_s3;

	assign mom_in[0] = momentum_x;
	assign mom_in[1] = momentum_y;
	assign mom_in[2] = momentum_z;

	always_comb begin
		for (int i = 0; i < igc_pkg::NUM_AXES; i++) begin
			neg_in[i] = mom_in[i][31];
			mag_in[i] = neg_in[i] ? (32'd0 - mom_in[i]) : mom_in[i];
		end
	end

	// velocity dividend is |m| << FRAC_BITS; its top word seeds the remainder
	always_comb begin
		for (int i = 0; i < igc_pkg::NUM_AXES; i++) begin
			num[i] = {32'd0, mag_s1[i]} << igc_pkg::FRAC_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rho_s1 <= density;
			et_s1  <= total_energy;
			mag_s1 <= mag_in;
			neg_s1 <= neg_in;
			bad_s1 <= density[31] || (density == 32'sd0);

			rho_s2 <= rho_s1;
			et_s2  <= et_s1;
			neg_s2 <= neg_s1;
			bad_s2 <= bad_s1;
			for (int i = 0; i < igc_pkg::NUM_AXES; i++) begin
				sq_s2[i]  <= 64'(mag_s1[i]) * 64'(mag_s1[i]);
				hi_s2[i]  <= num[i][63:32];
				lo_s2[i]  <= num[i][31:0];
				// quotient would reach 2^32
				ovf_s2[i] <= num[i][63:32] >= rho_s1;
			end

			rho_s3 <= rho_s2;
			et_s3  <= et_s2;
			neg_s3 <= neg_s2;
			bad_s3 <= bad_s2;
			hi_s3  <= hi_s2;
			lo_s3  <= lo_s2;
			ovf_s3 <= ovf_s2;
			msq_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	assign out_valid    = valid_s3;
	assign seed.bad_rho = bad_s3;
	assign seed.rho     = rho_s3;
	assign seed.et      = et_s3;
	assign seed.neg     = neg_s3;
	assign seed.vel_ovf = ovf_s3;
	assign seed.vel_hi  = hi_s3;
	assign seed.vel_lo  = lo_s3;
	assign seed.msq     = msq_s3;

endmodule

[rtl/core/igc_div.sv]
// ----------------------------------------------------------------------------
// igc_div
// Pipelined restoring divider, one quotient bit per stage. The caller must
// keep the seed remainder below the divisor, so that the quotient fits one
// word; the divider itself does not enforce it.
// ----------------------------------------------------------------------------
module igc_div (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] rem_in,
	input  logic [31:0] bits_in,
	input  logic [31:0] divisor,
	output logic [31:0] quot
);

	logic [31:0] rem_s  [igc_pkg::DIV_STEPS];
	logic [31:0] bits_s [igc_pkg::DIV_STEPS];
	logic [31:0] dvs_s  [igc_pkg::DIV_STEPS];

	for (genvar k = 0; k < igc_pkg::DIV_STEPS; k++) begin : g_step
		logic [31:0] rem_prev, bits_prev, dvs_prev;
		logic [32:0] trial, diff;
		logic        take;

		if (k == 0) begin : g_first
			assign rem_prev  = rem_in;
			assign bits_prev = bits_in;
			assign dvs_prev  = divisor;
		end else begin : g_next
			assign rem_prev  = rem_s[k-1];
			assign bits_prev = bits_s[k-1];
			assign dvs_prev  = dvs_s[k-1];
		end

		assign trial = {rem_prev, bits_prev[31]};
		assign diff  = trial - {1'b0, dvs_prev};
		assign take  = !diff[32];

		// dividend bits shift out of the top, quotient bits in at the bottom
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? diff[31:0] : trial[31:0];
				bits_s[k] <= {bits_prev[30:0], take};
				dvs_s[k]  <= dvs_prev;
			end
		end
	end

	assign quot = bits_s[igc_pkg::DIV_STEPS-1];

endmodule

[rtl/core/igc_back.sv]
// ----------------------------------------------------------------------------
// igc_back
// Velocity and internal energy saturation, the (gamma-1) product, then the
// pressure shift and status.
// ----------------------------------------------------------------------------
module igc_back (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               en,
	input  logic                                               in_valid,
	input  igc_pkg::side_t                                     side,
	input  logic [igc_pkg::DIV_COUNT-1:0][31:0]                quot,
	input  logic [igc_pkg::GAMMA_W-1:0]                        gamma,
	output logic                                               out_valid,
	output igc_pkg::prim_t                                     res
);

	logic [igc_pkg::NUM_AXES-1:0][31:0] vel_d;
	logic [igc_pkg::NUM_AXES-1:0]       vsat_d;
	logic [34:0]                        ediff;
	igc_pkg::sat_t                      eint_d;

	logic                               valid_b1, valid_b2;
	logic [igc_pkg::NUM_AXES-1:0][31:0] vel_b1, vel_b2;
	logic signed [31:0]                 eint_b1;
	logic [31:0]                        eint_b2;
	logic [31:0]                        rho_b1, rho_b2;
	logic                               sat_b1, sat_b2;
	logic                               bad_b1, bad_b2;
	logic signed [50:0]                 prod_b2;

	logic signed [igc_pkg::GAMMA_W:0]   gm1;
	logic [34:0]                        press_w;
	igc_pkg::sat_t                      press_d;

	always_comb begin
		for (int i = 0; i < igc_pkg::NUM_AXES; i++) begin
			if (side.vel_ovf[i]) begin
				vsat_d[i] = 1'b1;
				vel_d[i]  = side.neg[i] ? igc_pkg::MIN_WORD : igc_pkg::MAX_WORD;
			end else if (side.neg[i]) begin
				// a magnitude of exactly 2^31 still fits when negative
				vsat_d[i] = quot[i] > igc_pkg::MIN_WORD;
				vel_d[i]  = vsat_d[i] ? igc_pkg::MIN_WORD : (32'd0 - quot[i]);
			end else begin
				vsat_d[i] = quot[i][31];
				vel_d[i]  = quot[i][31] ? igc_pkg::MAX_WORD : quot[i];
			end
		end
		ediff  = {{3{side.et[31]}}, side.et} - {3'd0, quot[igc_pkg::KE_IDX]};
		eint_d = igc_pkg::sat_word(ediff);
		if (side.ke_ovf) begin
			eint_d.value = igc_pkg::MIN_WORD;
			eint_d.hit   = 1'b1;
		end
	end

	assign gm1 = $signed({1'b0, gamma}) - $signed(igc_pkg::GAMMA_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
			valid_b2 <= 1'b0;
		end else if (en) begin
			valid_b1 <= in_valid;
			valid_b2 <= valid_b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vel_b1  <= vel_d;
			eint_b1 <= eint_d.value;
			rho_b1  <= side.rho;
			sat_b1  <= (|vsat_d) | eint_d.hit;
			bad_b1  <= side.bad_rho;

			vel_b2  <= vel_b1;
			eint_b2 <= eint_b1;
			rho_b2  <= rho_b1;
			sat_b2  <= sat_b1;
			bad_b2  <= bad_b1;
			prod_b2 <= 51'(gm1) * 51'(eint_b1);
		end
	end

	// arithmetic shift of the product floors towards minus infinity
	assign press_w = prod_b2[50:igc_pkg::GAMMA_FRAC];
	assign press_d = igc_pkg::sat_word(press_w);

	always_comb begin
		if (bad_b2) begin
			res.rho    = '0;
			res.vx     = '0;
			res.vy     = '0;
			res.vz     = '0;
			res.eint   = '0;
			res.press  = '0;
			res.status = igc_pkg::ST_BAD_DENSITY;
		end else begin
			res.rho    = rho_b2;
			res.vx     = vel_b2[0];
			res.vy     = vel_b2[1];
			res.vz     = vel_b2[2];
			res.eint   = eint_b2;
			res.press  = press_d.value;
			res.status = (sat_b2 || press_d.hit) ? igc_pkg::ST_SATURATED : igc_pkg::ST_OK;
		end
	end

	assign out_valid = valid_b2;

endmodule

[rtl/core/igc_skid.sv]
// ----------------------------------------------------------------------------
// igc_skid
// Two-entry output buffer. The stall towards the pipeline is a register, so
// the receiver's ready never reaches the upstream side combinationally.
// ----------------------------------------------------------------------------
module igc_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  igc_pkg::prim_t data,
	output logic           full,
	output logic           out_valid,
	input  logic           out_ready,
	output igc_pkg::prim_t out_data
);

	logic           v0_q, v1_q;
	igc_pkg::prim_t e0_q, e1_q;
	logic           pop;

	assign pop = v0_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			v0_q <= push || v1_q || (v0_q && !pop);
			v1_q <= v1_q ? !pop : (push && v0_q && !pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && v1_q) begin
			e0_q <= e1_q;
		end else if (push && (!v0_q || pop)) begin
			e0_q <= data;
		end
		if (push && v0_q && !pop) begin
			e1_q <= data;
		end
	end

	assign full      = v1_q;
	assign out_valid = v0_q;
	assign out_data  = e0_q;

endmodule

[tb/tb_ideal_gas_cons_to_prim.sv]
// ----------------------------------------------------------------------------
// tb_ideal_gas_cons_to_prim
// Self-checking bench for the conserved-to-primitive converter. Cells are
// pushed in random bursts while the result side stalls on its own pattern.
// Each accepted cell is converted in exact integer arithmetic at the current
// adiabatic index. Each result is checked field by field, in order. The index
// is swept over its extremes between idle phases.
// ----------------------------------------------------------------------------
module tb_ideal_gas_cons_to_prim;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          QUIET_LIMIT  = 4000;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 48;
	localparam int          NUM_PHASES   = 7;
	localparam int          PHASE_ITEMS  = 112;
	localparam logic [31:0] W_MAX        = 32'h7FFF_FFFF;
	localparam logic [31:0] W_MIN        = 32'h8000_0000;
	localparam logic [31:0] Q_ONE        = 32'h0001_0000;

	typedef struct packed {
		logic signed [31:0] density;
		logic signed [31:0] mom_x;
		logic signed [31:0] mom_y;
		logic signed [31:0] mom_z;
		logic signed [31:0] energy;
	} cell_t;

	class prim_scoreboard;
		igc_pkg::prim_t              pending_prims[$];
		logic [igc_pkg::GAMMA_W-1:0] gamma;
		int                          failures;
		int                          results_seen;
		bit                          sat_hit;
		string                       bad_fields;

		function new();
			gamma        = igc_pkg::GAMMA_RESET;
			failures     = 0;
			results_seen = 0;
		endfunction

		function logic signed [31:0] clamp_word(logic signed [67:0] v);
			if (v > 68'sd2147483647) begin
				sat_hit = 1'b1;
				return W_MAX;
			end
			if (v < -68'sd2147483648) begin
				sat_hit = 1'b1;
				return W_MIN;
			end
			return v[31:0];
		endfunction

		function logic [31:0] magnitude_of(logic signed [31:0] v);
			return (v < 0) ? -v : v;
		endfunction

		// quotient truncated toward zero, density already known positive
		function logic signed [31:0] velocity_of(logic signed [31:0] m, logic signed [31:0] rho);
			logic [63:0]        quot;
			logic signed [67:0] v;
			quot = ({32'd0, magnitude_of(m)} << igc_pkg::FRAC_BITS) / {32'd0, rho};
			v    = $signed({4'd0, quot});
			if (m < 0)
				v = -v;
			return clamp_word(v);
		endfunction

		function igc_pkg::prim_t convert_cell(cell_t c);
			igc_pkg::prim_t     r;
			logic [65:0]        ax, ay, az, msq, two_rho;
			logic signed [67:0] diff;
			logic signed [19:0] gm1;
			logic signed [55:0] prod;
			r       = '0;
			sat_hit = 1'b0;
			if (c.density <= 0) begin
				r.status = igc_pkg::ST_BAD_DENSITY;
				return r;
			end
			ax      = 66'(magnitude_of(c.mom_x));
			ay      = 66'(magnitude_of(c.mom_y));
			az      = 66'(magnitude_of(c.mom_z));
			msq     = ax * ax + ay * ay + az * az;
			two_rho = 66'($unsigned(c.density)) << 1;
			diff    = 68'($signed(c.energy)) - $signed({2'b00, msq / two_rho});
			r.eint  = clamp_word(diff);
			// gamma - 1 may be negative; the arithmetic shift gives the floor
			gm1     = $signed({2'b00, gamma}) - 20'sd65536;
			prod    = 56'(gm1) * 56'($signed(r.eint));
			r.press = clamp_word(68'(prod >>> igc_pkg::GAMMA_FRAC));
			r.vx    = velocity_of(c.mom_x, c.density);
			r.vy    = velocity_of(c.mom_y, c.density);
			r.vz    = velocity_of(c.mom_z, c.density);
			r.rho   = c.density;
			r.status = sat_hit ? igc_pkg::ST_SATURATED : igc_pkg::ST_OK;
			return r;
		endfunction

		function void note_cell(cell_t c);
			pending_prims.push_back(convert_cell(c));
		endfunction

		function void diff_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got)
				bad_fields = {bad_fields, $sformatf(" %s exp %h got %h", name, want, got)};
		endfunction

		function void check_result(igc_pkg::prim_t got);
			igc_pkg::prim_t want;
			results_seen++;
			if (pending_prims.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result %0d: no cell pending", results_seen);
				return;
			end
			want       = pending_prims.pop_front();
			bad_fields = "";
			diff_field("rest_density", want.rho, got.rho);
			diff_field("velocity_x", want.vx, got.vx);
			diff_field("velocity_y", want.vy, got.vy);
			diff_field("velocity_z", want.vz, got.vz);
			diff_field("internal_energy", want.eint, got.eint);
			diff_field("pressure", want.press, got.press);
			diff_field("status", 32'(want.status), 32'(got.status));
			if (bad_fields != "") begin
				failures++;
				if (failures <= 10)
					$display("result %0d mismatch:%s", results_seen, bad_fields);
			end
		endfunction

		function int pending();
			return pending_prims.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	igc_cfg_if  cfg_ch();
	igc_cons_if cons_ch();
	igc_prim_if prim_ch();

	ideal_gas_cons_to_prim uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.cons   (cons_ch),
		.prim   (prim_ch)
	);

	prim_scoreboard sb = new();
	int             burst_left = 0;
	bit             hold_req   = 1'b0;
	int             quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side: a randomly redrawn stall pattern, plus one long hold-off
	initial begin
		int cyc;
		int stall_mode;
		cyc        = 0;
		stall_mode = 0;
		prim_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				prim_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			cyc++;
			if (cyc % 50 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0:       prim_ch.ready = 1'b1;
				1:       prim_ch.ready = ($urandom_range(0, 3) != 0);
				2:       prim_ch.ready = cyc[2];
				default: prim_ch.ready = ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		igc_pkg::prim_t got;
		if (arst_n && prim_ch.valid === 1'b1 && prim_ch.ready === 1'b1) begin
			got.rho    = prim_ch.rest_density;
			got.vx     = prim_ch.velocity_x;
			got.vy     = prim_ch.velocity_y;
			got.vz     = prim_ch.velocity_z;
			got.eint   = prim_ch.internal_energy;
			got.press  = prim_ch.pressure;
			got.status = prim_ch.status;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cons_ch.valid && cons_ch.ready) || (prim_ch.valid && prim_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 5))
			0, 1:    return $urandom;
			2:       return ($urandom_range(0, 1) != 0) ? -$urandom_range(0, 1 << 20)
				: $urandom_range(0, 1 << 20);
			3:       return ($urandom_range(0, 1) != 0) ? -$urandom_range(0, 1 << 26)
				: $urandom_range(0, 1 << 26);
			4: begin
				case ($urandom_range(0, 4))
					0:       return W_MAX;
					1:       return W_MIN;
					2:       return 32'hFFFF_FFFF;
					3:       return Q_ONE;
					default: return 32'd1;
				endcase
			end
			default: return 32'd0;
		endcase
	endfunction

	function automatic cell_t random_cell();
		cell_t c;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 2))
					0:       c.density = 32'd0;
					1:       c.density = W_MIN;
					default: c.density = {1'b1, 31'($urandom)};
				endcase
			end
			1, 2, 3: c.density = $urandom_range(1, 255);
			4, 5, 6, 7: c.density = $urandom_range(16384, 262144);
			default: c.density = $urandom_range(1, 32'h7FFF_FFFF);
		endcase
		c.mom_x  = random_word();
		c.mom_y  = random_word();
		c.mom_z  = random_word();
		c.energy = random_word();
		return c;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_cell(cell_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (hold_req)
				gap = 0;
			if (gap != 0) begin
				cons_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cons_ch.density      = c.density;
		cons_ch.momentum_x   = c.mom_x;
		cons_ch.momentum_y   = c.mom_y;
		cons_ch.momentum_z   = c.mom_z;
		cons_ch.total_energy = c.energy;
		cons_ch.valid        = 1'b1;
		do @(posedge clk); while (cons_ch.ready !== 1'b1);
		sb.note_cell(c);
		@(negedge clk);
	endtask

	task automatic send_fields(logic [31:0] d, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] e);
		cell_t c;
		c = '{d, x, y, z, e};
		send_cell(c);
	endtask

	task automatic drain();
		cons_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_gamma(logic [igc_pkg::GAMMA_W-1:0] g);
		cfg_ch.adiabatic_index = g;
		cfg_ch.valid           = 1'b1;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		sb.gamma = g;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	initial begin
		logic [igc_pkg::GAMMA_W-1:0] g;
		arst_n                 = 1'b0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.adiabatic_index = '0;
		cons_ch.valid          = 1'b0;
		cons_ch.density        = '0;
		cons_ch.momentum_x     = '0;
		cons_ch.momentum_y     = '0;
		cons_ch.momentum_z     = '0;
		cons_ch.total_energy   = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_fields(32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
		send_fields(32'd0, 32'd1, 32'd1, 32'd1, 32'd1);
		send_fields(32'hFFFF_FFFF, W_MAX, W_MAX, W_MAX, W_MAX);
		send_fields(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
		send_fields(W_MAX, W_MAX, W_MIN, W_MIN, W_MAX);
		send_fields(32'd1, W_MAX, 32'd0, 32'd0, 32'd0);
		send_fields(32'd1, W_MIN, 32'd0, 32'd0, 32'd0);
		send_fields(Q_ONE, Q_ONE, -32'sh20000, 32'h8000, 32'h5_0000);
		// quotients that truncate toward zero
		send_fields(32'h2_0000, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0);
		send_fields(Q_ONE, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
		send_fields(32'd1, 32'h100, 32'd0, 32'd0, W_MIN);
		send_fields(W_MAX, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
		send_fields(Q_ONE, 32'd0, 32'd0, 32'd0, W_MAX);
		send_fields(Q_ONE, 32'd0, 32'd0, 32'd0, W_MIN);
		send_fields(32'h7FFF, 32'h1_2345, -32'sh6_789A, 32'd1, 32'hA_0000);
		send_fields(32'd1, 32'd1, 32'd1, 32'd1, 32'd1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p != 0) begin
				case (p)
					1:       g = 18'd65536;
					2:       g = 18'd196608;
					3:       g = 18'd0;
					4:       g = 18'h3FFFF;
					5:       g = 18'($urandom_range(65536, 196608));
					default: g = 18'($urandom_range(0, 18'h3FFFF));
				endcase
				drain();
				write_gamma(g);
			end
			// the result side holds off while cells keep coming, so the pipe backs up
			if (p == 2)
				hold_req = 1'b1;
			send_fields(Q_ONE, 32'd0, 32'd0, 32'd0, W_MAX);
			send_fields(Q_ONE, 32'd0, 32'd0, 32'd0, W_MIN);
			send_fields(32'd1, 32'h40, -32'sh40, 32'd0, 32'hFFFF_FFFF);
			repeat (PHASE_ITEMS) send_cell(random_cell());
		end
		drain();

		if (sb.pending() != 0)
			$display("%0d results never arrived", sb.pending());
		if (sb.failures == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
